### hdl/cla_pkg.sv
package cla_pkg;

	// list geometry
	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// fixed field widths of the channels
	localparam int CMD_W  = 4;
	localparam int VAL_W  = 32;
	localparam int RIDX_W = 5;
	localparam int CNTF_W = 6;
	localparam int ERR_W  = 3;

	// common width for comparing the read index against the count
	localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_START        = 4'd0,
		CMD_END          = 4'd1,
		CMD_ADVANCE      = 4'd2,
		CMD_RETREAT      = 4'd3,
		CMD_INSERT       = 4'd4,
		CMD_ATTACH       = 4'd5,
		CMD_REMOVE       = 4'd6,
		CMD_INSERT_FRONT = 4'd7,
		CMD_APPEND_BACK  = 4'd8,
		CMD_REMOVE_FRONT = 4'd9,
		CMD_READ         = 4'd10
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK       = 3'd0,
		ERR_FULL     = 3'd1,
		ERR_NO_CUR   = 3'd2,
		ERR_AT_START = 3'd3,
		ERR_INDEX    = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_OPEN,
		OP_CLOSE
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_GATHER
	} state_t;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// shift command broadcast to every cell
	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] pos;
		word_t            value;
	} cell_ctl_t;

	// which cells drive the current and read chains
	typedef struct packed {
		logic             cur_en;
		logic [IDX_W-1:0] cur_pos;
		logic             rd_en;
		logic [IDX_W-1:0] rd_pos;
	} gather_t;

	// channel word to stored word: low DATA_WIDTH bits, zero filled above
	function automatic word_t from_field(input logic [VAL_W-1:0] f);
		logic [63:0] t;
		t = {32'b0, f};
		return t[DATA_WIDTH-1:0];
	endfunction

	// stored word to channel word: zero extended, low 32 bits kept
	function automatic logic [VAL_W-1:0] to_field(input word_t w);
		logic [63:0] t;
		t = 64'(w);
		return t[VAL_W-1:0];
	endfunction

endpackage

### hdl/cla_req_if.sv
interface cla_req_if;
	import cla_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [VAL_W-1:0]  entry_value;
	logic [RIDX_W-1:0]        read_index;

	modport source (output valid, command, entry_value, read_index, input ready);
	modport sink   (input valid, command, entry_value, read_index, output ready);
endinterface

### hdl/cla_rsp_if.sv
interface cla_rsp_if;
	import cla_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CNTF_W-1:0]        item_count;
	logic                     has_current;
	logic signed [VAL_W-1:0]  current_value;
	logic signed [VAL_W-1:0]  read_value;
	logic [ERR_W-1:0]         error_code;

	modport source (output valid, item_count, has_current, current_value, read_value,
		error_code, input ready);
	modport sink   (input valid, item_count, has_current, current_value, read_value,
		error_code, output ready);
endinterface

### hdl/cla_cell.sv
module cla_cell (
	input  logic                      clk,
	input  cla_pkg::cell_ctl_t        ctl,
	input  cla_pkg::gather_t          gather,
	input  logic [cla_pkg::IDX_W-1:0] index,
	input  cla_pkg::word_t            left_word,
	input  cla_pkg::word_t            right_word,
	input  cla_pkg::word_t            cur_in,
	input  cla_pkg::word_t            rd_in,
	output cla_pkg::word_t            word,
	output cla_pkg::word_t            cur_out,
	output cla_pkg::word_t            rd_out
);
	import cla_pkg::*;

	word_t data_q;

	// open a gap at pos (shift up) or close it (shift down)
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_OPEN: begin
				if (index == ctl.pos) begin
					data_q <= ctl.value;
				end else if (index > ctl.pos) begin
					data_q <= left_word;
				end
			end
			OP_CLOSE: begin
				if (index >= ctl.pos) begin
					data_q <= right_word;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign word = data_q;

	// merge own word into the chains when selected
	assign cur_out = (gather.cur_en && gather.cur_pos == index) ? (cur_in | data_q) : cur_in;
	assign rd_out  = (gather.rd_en && gather.rd_pos == index) ? (rd_in | data_q) : rd_in;

endmodule

### hdl/cla_ctrl.sv
module cla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	cla_req_if.sink            req,
	cla_rsp_if.source          rsp,
	input  cla_pkg::word_t     cur_word,
	input  cla_pkg::word_t     rd_word,
	output cla_pkg::cell_ctl_t cell_ctl,
	output cla_pkg::gather_t   gather
);
	import cla_pkg::*;

	state_t state_q, state_nxt;

	logic [CMD_W-1:0]  cmd_q;
	word_t             val_q;
	logic [RIDX_W-1:0] idx_q;

	logic [CNT_W-1:0] cursor_q, count_q;
	err_t             err_q;
	logic             rd_en_q;
	logic [IDX_W-1:0] rd_pos_q;

	logic [CNT_W-1:0] cursor_nxt, count_nxt;
	err_t             err_nxt;
	logic             rd_en_nxt;
	cell_op_t         op_nxt;
	logic [IDX_W-1:0] pos_nxt;
	logic             has, full;

	logic req_fire, in_apply, load_rsp;

	logic              rsp_valid_q;
	logic [CNTF_W-1:0] rsp_count_q;
	logic              rsp_has_q;
	logic [VAL_W-1:0]  rsp_cur_q;
	logic [VAL_W-1:0]  rsp_rd_q;
	err_t              rsp_err_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_nxt = ST_GATHER;
			end
			ST_GATHER: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		req.ready = 1'b0;
		in_apply  = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_APPLY: begin
				in_apply = 1'b1;
			end
			ST_GATHER: begin
				load_rsp = !rsp_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign req_fire = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= req.command;
			val_q <= from_field(req.entry_value);
			idx_q <= req.read_index;
		end
	end

	// command decode against the current cursor and count
	always_comb begin
		has        = cursor_q < count_q;
		full       = count_q >= CNT_W'(CAPACITY);
		cursor_nxt = cursor_q;
		count_nxt  = count_q;
		err_nxt    = ERR_OK;
		rd_en_nxt  = 1'b0;
		op_nxt     = OP_HOLD;
		pos_nxt    = '0;
		case (cmd_t'(cmd_q))
			CMD_START: begin
				cursor_nxt = '0;
			end
			CMD_END: begin
				cursor_nxt = (count_q == '0) ? '0 : count_q - CNT_W'(1);
			end
			CMD_ADVANCE: begin
				if (!has) err_nxt = ERR_NO_CUR;
				else cursor_nxt = cursor_q + CNT_W'(1);
			end
			CMD_RETREAT: begin
				if (cursor_q == '0) err_nxt = ERR_AT_START;
				else cursor_nxt = cursor_q - CNT_W'(1);
			end
			CMD_INSERT: begin
				if (full) begin
					err_nxt = ERR_FULL;
				end else begin
					pos_nxt    = has ? IDX_W'(cursor_q) : '0;
					cursor_nxt = has ? cursor_q : '0;
					count_nxt  = count_q + CNT_W'(1);
					op_nxt     = OP_OPEN;
				end
			end
			CMD_ATTACH: begin
				if (full) begin
					err_nxt = ERR_FULL;
				end else begin
					cursor_nxt = has ? cursor_q + CNT_W'(1) : count_q;
					pos_nxt    = has ? IDX_W'(cursor_q + CNT_W'(1)) : IDX_W'(count_q);
					count_nxt  = count_q + CNT_W'(1);
					op_nxt     = OP_OPEN;
				end
			end
			CMD_REMOVE: begin
				if (!has) begin
					err_nxt = ERR_NO_CUR;
				end else begin
					pos_nxt   = IDX_W'(cursor_q);
					count_nxt = count_q - CNT_W'(1);
					op_nxt    = OP_CLOSE;
				end
			end
			CMD_INSERT_FRONT: begin
				if (full) begin
					err_nxt = ERR_FULL;
				end else begin
					cursor_nxt = '0;
					count_nxt  = count_q + CNT_W'(1);
					op_nxt     = OP_OPEN;
				end
			end
			CMD_APPEND_BACK: begin
				if (full) begin
					err_nxt = ERR_FULL;
				end else begin
					pos_nxt    = IDX_W'(count_q);
					cursor_nxt = count_q;
					count_nxt  = count_q + CNT_W'(1);
					op_nxt     = OP_OPEN;
				end
			end
			CMD_REMOVE_FRONT: begin
				if (!has) begin
					err_nxt = ERR_NO_CUR;
				end else begin
					cursor_nxt = '0;
					count_nxt  = count_q - CNT_W'(1);
					op_nxt     = OP_CLOSE;
				end
			end
			CMD_READ: begin
				if (CMP_W'(idx_q) >= CMP_W'(count_q)) err_nxt = ERR_INDEX;
				else rd_en_nxt = 1'b1;
			end
			default: begin
				err_nxt = ERR_OK;
			end
		endcase
	end

	// shift command to the cells, live only in the apply cycle
	assign cell_ctl.op    = in_apply ? op_nxt : OP_HOLD;
	assign cell_ctl.pos   = pos_nxt;
	assign cell_ctl.value = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			count_q  <= '0;
		end else if (in_apply) begin
			cursor_q <= cursor_nxt;
			count_q  <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_apply) begin
			err_q    <= err_nxt;
			rd_en_q  <= rd_en_nxt;
			rd_pos_q <= IDX_W'(idx_q);
		end
	end

	// select the cells that feed the chains after the shift
	assign gather.cur_en  = cursor_q < count_q;
	assign gather.cur_pos = IDX_W'(cursor_q);
	assign gather.rd_en   = rd_en_q;
	assign gather.rd_pos  = rd_pos_q;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_count_q <= CNTF_W'(count_q);
			rsp_has_q   <= gather.cur_en;
			rsp_cur_q   <= to_field(cur_word);
			rsp_rd_q    <= to_field(rd_word);
			rsp_err_q   <= err_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.item_count    = rsp_count_q;
	assign rsp.has_current   = rsp_has_q;
	assign rsp.current_value = rsp_cur_q;
	assign rsp.read_value    = rsp_rd_q;
	assign rsp.error_code    = rsp_err_q;

endmodule

### hdl/cursor_array_list.sv
// Ordered list of up to CAPACITY words with a cursor, held in a row of cells that each store
// one entry and shift to their neighbour on inserts and removes. Idle accepts a command; apply
// decodes it and shifts the cell row; gather passes the current and indexed entries along the
// cell chain into the result register, holding while an earlier result is unread, then returns
// to idle for the next word, and a finished result may wait on the output while the next
// command is taken. Misused commands return an error code and leave the list as it was. Entries
// carry no reset; only positions below the count are ever read.
module cursor_array_list (
	input  logic  clk,
	input  logic  arst_n,
	cla_req_if.sink   req,
	cla_rsp_if.source rsp
);
	import cla_pkg::*;

	cell_ctl_t cell_ctl;
	gather_t   gather;

	word_t words   [CAPACITY];
	word_t cur_ch  [CAPACITY+1];
	word_t rd_ch   [CAPACITY+1];

	cla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cur_word (cur_ch[CAPACITY]),
		.rd_word  (rd_ch[CAPACITY]),
		.cell_ctl (cell_ctl),
		.gather   (gather)
	);

	assign cur_ch[0] = '0;
	assign rd_ch[0]  = '0;

	// row of entry cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w, right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		cla_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.gather     (gather),
			.index      (IDX_W'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.cur_in     (cur_ch[i]),
			.rd_in      (rd_ch[i]),
			.word       (words[i]),
			.cur_out    (cur_ch[i+1]),
			.rd_out     (rd_ch[i+1])
		);
	end

	// no new word is taken in the cycle after one was accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous command in progress");

	// a result is registered after the apply and gather states when the output was empty at acceptance
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && !rsp.valid |=> ##2 rsp.valid)
		else $error("result missing after command");

	// read data only on a successful command
	a_read_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.read_value != '0 |-> rsp.error_code == ERR_OK)
		else $error("read data with error code");

	// no current value without a current item
	a_cur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.has_current |-> rsp.current_value == '0)
		else $error("current value without current item");

endmodule

### tb/cursor_array_list_checker.sv
module cursor_array_list_checker
	import cla_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cla_req_if   req,
	cla_rsp_if   rsp,
	output int   failures,
	output int   outstanding
);

	typedef struct packed {
		logic [CNTF_W-1:0] item_count;
		logic              has_current;
		logic [VAL_W-1:0]  current_value;
		logic [VAL_W-1:0]  read_value;
		err_t              error_code;
	} list_status_t;

	// shadow copy of the list
	word_t            entries [CAPACITY];
	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] cursor;

	// statuses still owed by the block, oldest first
	list_status_t status_q [$];

	// shift later entries up by one and store the new word at pos
	function automatic void open_slot(input logic [CNT_W-1:0] pos, input word_t w);
		for (int i = int'(count); i > int'(pos); i--)
			entries[IDX_W'(i)] = entries[IDX_W'(i-1)];
		entries[IDX_W'(pos)] = w;
		count++;
	endfunction

	// drop the entry at pos, pulling later entries down
	function automatic void close_slot(input logic [CNT_W-1:0] pos);
		for (int i = int'(pos); i + 1 < int'(count); i++)
			entries[IDX_W'(i)] = entries[IDX_W'(i+1)];
		count--;
	endfunction

	// run one command on the shadow list and work out the status word
	function automatic list_status_t apply_command(input logic [CMD_W-1:0] cmd,
		input logic [VAL_W-1:0] value, input logic [RIDX_W-1:0] index);
		list_status_t st;
		logic         has;
		logic         full;
		word_t        w;
		st = '0;
		st.error_code = ERR_OK;
		has = cursor < count;
		full = count >= CAPACITY;
		w = word_t'(value);
		case (cmd)
			CMD_START: begin
				cursor = '0;
			end
			CMD_END: begin
				cursor = (count == 0) ? '0 : count - 1'b1;
			end
			CMD_ADVANCE: begin
				if (!has) st.error_code = ERR_NO_CUR;
				else cursor++;
			end
			CMD_RETREAT: begin
				if (cursor == 0) st.error_code = ERR_AT_START;
				else cursor--;
			end
			CMD_INSERT: begin
				if (full) st.error_code = ERR_FULL;
				else begin
					// no current item: goes to the front
					if (!has) cursor = '0;
					open_slot(cursor, w);
				end
			end
			CMD_ATTACH: begin
				if (full) st.error_code = ERR_FULL;
				else begin
					// no current item: goes to the back
					cursor = has ? cursor + 1'b1 : count;
					open_slot(cursor, w);
				end
			end
			CMD_REMOVE: begin
				if (!has) st.error_code = ERR_NO_CUR;
				else close_slot(cursor);
			end
			CMD_INSERT_FRONT: begin
				if (full) st.error_code = ERR_FULL;
				else begin
					open_slot('0, w);
					cursor = '0;
				end
			end
			CMD_APPEND_BACK: begin
				if (full) st.error_code = ERR_FULL;
				else begin
					open_slot(count, w);
					cursor = count - 1'b1;
				end
			end
			CMD_REMOVE_FRONT: begin
				if (!has) st.error_code = ERR_NO_CUR;
				else begin
					close_slot('0);
					cursor = '0;
				end
			end
			CMD_READ: begin
				if (index >= count) st.error_code = ERR_INDEX;
				else st.read_value = VAL_W'(entries[index]);
			end
			default: begin
				// unused codes change nothing
			end
		endcase
		has = cursor < count;
		st.item_count = CNTF_W'(count);
		st.has_current = has;
		st.current_value = has ? VAL_W'(entries[IDX_W'(cursor)]) : '0;
		return st;
	endfunction

	// compare each result word with the oldest prediction, then predict new words
	always @(posedge clk or negedge arst_n) begin
		list_status_t want;
		int           bad;
		if (!arst_n) begin
			count = '0;
			cursor = '0;
			status_q.delete();
			outstanding <= 0;
			failures <= 0;
		end else begin
			bad = 0;
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					$error("result word with no command waiting");
					bad++;
				end else begin
					want = status_q.pop_front();
					if (rsp.item_count !== want.item_count) begin
						$error("item_count: expected %0d, got %0d",
							want.item_count, rsp.item_count);
						bad++;
					end
					if (rsp.has_current !== want.has_current) begin
						$error("has_current: expected %0d, got %0d",
							want.has_current, rsp.has_current);
						bad++;
					end
					if (rsp.current_value !== want.current_value) begin
						$error("current_value: expected %h, got %h",
							want.current_value, rsp.current_value);
						bad++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h",
							want.read_value, rsp.read_value);
						bad++;
					end
					if (rsp.error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d",
							want.error_code, rsp.error_code);
						bad++;
					end
				end
			end
			if (req.valid && req.ready)
				status_q.push_back(apply_command(req.command, req.entry_value,
					req.read_index));
			outstanding <= status_q.size();
			failures <= failures + bad;
		end
	end

endmodule

### tb/cursor_array_list_tb.sv
module cursor_array_list_tb;
	import cla_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	cla_req_if req ();
	cla_rsp_if rsp ();

	int failures;
	int outstanding;
	int words_sent;
	bit steady;

	cursor_array_list i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	cursor_array_list_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// overall time limit
	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	// offer one command word, sometimes after a random gap, and wait for it to be taken
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
		input logic [RIDX_W-1:0] index);
		int gap;
		if (!steady && $urandom_range(99) < 34) begin
			gap = $urandom_range(4, 1);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.entry_value <= value;
		req.read_index <= index;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		words_sent++;
	endtask

	// stop offering and wait until every predicted status has come back
	task automatic drain_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && words_sent >= 300) begin
				// long hold so the block fills up and stalls its input
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			rsp.ready <= steady || ($urandom_range(99) >= 34);
		end
	end

	// command side and verdict
	initial begin
		cmd_t                grow_cmds [4];
		cmd_t                shrink_cmds [2];
		logic [VAL_W-1:0]    edge_vals [4];
		logic [CMD_W-1:0]    cmd;
		logic [VAL_W-1:0]    value;
		logic [RIDX_W-1:0]   index;
		int                  mode;
		int                  span;
		int                  roll;
		int                  n;

		grow_cmds = '{CMD_INSERT, CMD_ATTACH, CMD_INSERT_FRONT, CMD_APPEND_BACK};
		shrink_cmds = '{CMD_REMOVE, CMD_REMOVE_FRONT};
		edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
		steady = 1'b0;
		words_sent = 0;
		req.valid <= 1'b0;
		req.command <= CMD_START;
		req.entry_value <= '0;
		req.read_index <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// misuse on an empty list
		send_word(CMD_REMOVE, '0, '0);
		send_word(CMD_ADVANCE, '0, '0);
		send_word(CMD_RETREAT, '0, '0);
		send_word(CMD_REMOVE_FRONT, '0, '0);
		send_word(CMD_END, '0, '0);
		send_word(CMD_READ, '0, '0);
		// insert with no current item lands at the front
		send_word(CMD_INSERT, 32'h7fff_ffff, '0);
		send_word(CMD_ATTACH, 32'h8000_0000, '0);
		send_word(CMD_START, '0, '0);
		send_word(CMD_INSERT, 32'hffff_ffff, '0);
		send_word(CMD_APPEND_BACK, 32'h0000_0000, '0);
		// step past the end, then advance and retreat with no current item
		send_word(CMD_ADVANCE, '0, '0);
		send_word(CMD_ADVANCE, '0, '0);
		send_word(CMD_RETREAT, '0, '0);
		// attach with no current item lands at the back
		send_word(CMD_ADVANCE, '0, '0);
		send_word(CMD_ATTACH, 32'h5a5a_5a5a, '0);
		send_word(CMD_ADVANCE, '0, '0);
		send_word(CMD_INSERT, 32'ha5a5_a5a5, '0);
		// removing the last entry leaves no current item
		send_word(CMD_END, '0, '0);
		send_word(CMD_REMOVE, '0, '0);
		send_word(CMD_INSERT_FRONT, 32'h0000_0001, '0);
		send_word(CMD_REMOVE_FRONT, '0, '0);
		send_word(CMD_READ, '0, RIDX_W'(2));
		send_word(CMD_READ, '0, '1);
		send_word({CMD_W{1'b1}}, 32'hdead_beef, '1);

		drain_results();

		// random episodes that grow, shrink or churn the list
		n = 0;
		while (n < 1000) begin
			mode = $urandom_range(2);
			span = $urandom_range(80, 30);
			for (int k = 0; k < span; k++) begin
				steady = (n >= 550 && n < 700);
				roll = $urandom_range(99);
				if (roll < 3)
					cmd = CMD_W'($urandom_range((1 << CMD_W) - 1, int'(CMD_READ) + 1));
				else if (mode == 0 && roll < 72)
					cmd = grow_cmds[$urandom_range(3)];
				else if (mode == 1 && roll < 60)
					cmd = shrink_cmds[$urandom_range(1)];
				else
					cmd = cmd_t'($urandom_range(int'(CMD_READ)));
				value = ($urandom_range(9) == 0) ? edge_vals[$urandom_range(3)] : $urandom;
				index = ($urandom_range(1) == 0) ? RIDX_W'($urandom)
					: RIDX_W'($urandom_range(7));
				send_word(cmd, value, index);
				n++;
			end
		end

		drain_results();
		repeat (20) @(posedge clk);

		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/cla_pkg.sv
hdl/cla_req_if.sv
hdl/cla_rsp_if.sv
hdl/cla_cell.sv
hdl/cla_ctrl.sv
hdl/cursor_array_list.sv
tb/cursor_array_list_checker.sv
tb/cursor_array_list_tb.sv
